// ===== hdl/hmu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hmu_pkg
// shared types and sizes for the hermitian matrix unpacker
// ----------------------------------------------------------------------------
package hmu_pkg;

    localparam int NUM_FREQ     = 8;
    localparam int NUM_STATIONS = 32;
    localparam int NUM_POLS     = 2;

    localparam int HALF_ST       = (NUM_STATIONS + 1) / 2;
    localparam int TILES_PER_SUB = (HALF_ST * (HALF_ST + 1)) / 2;
    localparam int PLANE_WORDS   = NUM_FREQ * 4 * TILES_PER_SUB * NUM_POLS * NUM_POLS;
    localparam int STORE_WORDS   = 2 * PLANE_WORDS;
    localparam int PLANE_AW      = $clog2(PLANE_WORDS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

    typedef logic [PLANE_AW-1:0] addr_t;
    typedef logic [31:0]         word_t;

    // one classified operation travelling from front to back
    typedef struct packed {
        logic  is_read;
        logic  wr_real;
        logic  wr_imag;
        addr_t addr;
        word_t data;
        logic  mirror;
        logic  zero;
    } op_t;

endpackage
`default_nettype wire

// ===== hdl/hmu_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hmu_front
// accepts commands, classifies loads and reads, computes tile addresses
// ----------------------------------------------------------------------------
module hmu_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire logic           mode,
    input  wire logic [15:0]    word_addr,
    input  wire logic [31:0]    word_value,
    input  wire logic [2:0]     freq_chan,
    input  wire logic [4:0]     row_station,
    input  wire logic [4:0]     col_station,
    input  wire logic           row_pol,
    input  wire logic           col_pol,
    output logic                q_valid,
    output hmu_pkg::op_t        q_op,
    input  wire logic           q_full
);

    logic         valid_reg;
    logic         valid_next;
    hmu_pkg::op_t op_reg;
    hmu_pkg::op_t op_next;

    logic         push;
    logic         accept;
    logic         mirror;
    logic [4:0]   r_st;
    logic [4:0]   c_st;
    logic         rp_eff;
    logic         cp_eff;
    logic         pr;
    logic         pc;
    logic [31:0]  rh;
    logic [31:0]  ch;
    logic [31:0]  tile;
    logic [31:0]  slot;
    logic         in_range;

    assign push   = valid_reg && !q_full;
    assign busy   = valid_reg && q_full;
    assign accept = start && !busy;

    assign q_valid = valid_reg;
    assign q_op    = op_reg;

    always_comb
    begin
        rp_eff = (hmu_pkg::NUM_POLS == 2) ? row_pol : 1'b0;
        cp_eff = (hmu_pkg::NUM_POLS == 2) ? col_pol : 1'b0;
        mirror = row_station < col_station;
        r_st   = mirror ? col_station : row_station;
        c_st   = mirror ? row_station : col_station;
        pr     = mirror ? cp_eff : rp_eff;
        pc     = mirror ? rp_eff : cp_eff;
        rh     = 32'(r_st[4:1]);
        ch     = 32'(c_st[4:1]);
        // tile = (f*4 + sub)*T + tri(rh) + ch
        tile   = (32'(freq_chan) * 32'd4 + 32'({c_st[0], r_st[0]}))
                 * 32'(hmu_pkg::TILES_PER_SUB)
                 + ((rh * (rh + 32'd1)) >> 1) + ch;
        slot   = tile * 32'(hmu_pkg::NUM_POLS * hmu_pkg::NUM_POLS)
                 + 32'(pr) * 32'(hmu_pkg::NUM_POLS) + 32'(pc);
        in_range = (32'(freq_chan) < 32'(hmu_pkg::NUM_FREQ))
                   && (32'(row_station) < 32'(hmu_pkg::NUM_STATIONS))
                   && (32'(col_station) < 32'(hmu_pkg::NUM_STATIONS))
                   && (slot < 32'(hmu_pkg::PLANE_WORDS));

        op_next         = op_reg;
        op_next.is_read = (mode == hmu_pkg::MODE_READ);
        op_next.data    = word_value;
        op_next.mirror  = mirror;
        op_next.zero    = !in_range;
        if (mode == hmu_pkg::MODE_READ)
        begin
            op_next.wr_real = 1'b0;
            op_next.wr_imag = 1'b0;
            op_next.addr    = hmu_pkg::addr_t'(slot);
        end
        else if (32'(word_addr) < 32'(hmu_pkg::PLANE_WORDS))
        begin
            op_next.wr_real = 1'b1;
            op_next.wr_imag = 1'b0;
            op_next.addr    = hmu_pkg::addr_t'(word_addr);
        end
        else
        begin
            op_next.wr_real = 1'b0;
            // load beyond the store is dropped
            op_next.wr_imag = 32'(word_addr) < 32'(hmu_pkg::STORE_WORDS);
            op_next.addr    = hmu_pkg::addr_t'(32'(word_addr)
                                               - 32'(hmu_pkg::PLANE_WORDS));
        end

        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            op_reg <= op_next;
    end

endmodule
`default_nettype wire

// ===== hdl/hmu_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hmu_queue
// short operation queue between front and back
// ----------------------------------------------------------------------------
module hmu_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire hmu_pkg::op_t   push_op,
    output logic                full,
    input  wire logic           pop,
    output logic                empty,
    output hmu_pkg::op_t        head
);

    hmu_pkg::op_t                 entry_reg [hmu_pkg::QUEUE_DEPTH];
    logic [hmu_pkg::QUEUE_PW-1:0] wr_ptr_reg;
    logic [hmu_pkg::QUEUE_PW-1:0] rd_ptr_reg;
    logic [hmu_pkg::QUEUE_PW:0]   count_reg;
    logic [hmu_pkg::QUEUE_PW:0]   count_next;
    logic                         do_push;
    logic                         do_pop;

    assign full    = count_reg == (hmu_pkg::QUEUE_PW + 1)'(hmu_pkg::QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule
`default_nettype wire

// ===== hdl/hmu_plane_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hmu_plane_ram
// one plane of the tile store, single port, registered read
// ----------------------------------------------------------------------------
module hmu_plane_ram (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic           we,
    input  wire hmu_pkg::addr_t addr,
    input  wire hmu_pkg::word_t wdata,
    output hmu_pkg::word_t      rdata
);

    hmu_pkg::word_t mem [hmu_pkg::PLANE_WORDS];
    hmu_pkg::word_t rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/hmu_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hmu_back
// executes queued operations against the two store planes
// ----------------------------------------------------------------------------
module hmu_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire hmu_pkg::op_t   q_head,
    output logic                q_pop,
    output logic                done,
    output logic [31:0]         real_bits,
    output logic [31:0]         imag_bits
);

    hmu_pkg::word_t real_rd;
    hmu_pkg::word_t imag_rd;
    logic           rd_valid_reg;
    logic           mirror_reg;
    logic           zero_reg;
    logic           done_reg;
    logic [31:0]    real_bits_reg;
    logic [31:0]    imag_bits_reg;

    // back never stalls: one operation per cycle
    assign q_pop = !q_empty;

    hmu_plane_ram u_real_ram (
        .clk   (clk),
        .en    (q_pop && (q_head.is_read || q_head.wr_real)),
        .we    (q_head.wr_real),
        .addr  (q_head.addr),
        .wdata (q_head.data),
        .rdata (real_rd)
    );

    hmu_plane_ram u_imag_ram (
        .clk   (clk),
        .en    (q_pop && (q_head.is_read || q_head.wr_imag)),
        .we    (q_head.wr_imag),
        .addr  (q_head.addr),
        .wdata (q_head.data),
        .rdata (imag_rd)
    );

    assign done      = done_reg;
    assign real_bits = real_bits_reg;
    assign imag_bits = imag_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= q_pop && q_head.is_read;
            done_reg     <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_head.is_read)
        begin
            mirror_reg <= q_head.mirror;
            zero_reg   <= q_head.zero;
        end
        if (rd_valid_reg)
        begin
            real_bits_reg <= zero_reg ? '0 : real_rd;
            imag_bits_reg <= zero_reg ? '0
                           : (mirror_reg ? (imag_rd ^ hmu_pkg::SIGN_MASK) : imag_rd);
        end
    end

endmodule
`default_nettype wire

// ===== hdl/hermitian_matrix_unpacker.sv =====
`default_nettype none
// a read reaches the result ports through the front register, the queue, the plane ram
// read and the output register; loads give no result
// throughput: one word per cycle while busy is low, set by the single port of each store plane
// the result strobe is a one-cycle pulse; the receiver cannot stall
// reset clears the queue and all valid flags; the tile store is not cleared
// ----------------------------------------------------------------------------
// hermitian_matrix_unpacker
// serves full hermitian matrix elements from a register-tile correlator dump
// ----------------------------------------------------------------------------
module hermitian_matrix_unpacker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire logic           mode,
    input  wire logic [15:0]    word_addr,
    input  wire logic [31:0]    word_value,
    input  wire logic [2:0]     freq_chan,
    input  wire logic [4:0]     row_station,
    input  wire logic [4:0]     col_station,
    input  wire logic           row_pol,
    input  wire logic           col_pol,
    output logic                done,
    output logic [31:0]         real_bits,
    output logic [31:0]         imag_bits
);

    // front to queue
    logic         f_valid;
    hmu_pkg::op_t f_op;
    logic         q_full;

    // queue to back
    logic         q_empty;
    logic         q_pop;
    hmu_pkg::op_t q_head;

    // front: takes one word per cycle while not busy, works out the tile slot and whether
    // the pair is mirrored (row station below column station)
    hmu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .word_addr   (word_addr),
        .word_value  (word_value),
        .freq_chan   (freq_chan),
        .row_station (row_station),
        .col_station (col_station),
        .row_pol     (row_pol),
        .col_pol     (col_pol),
        .q_valid     (f_valid),
        .q_op        (f_op),
        .q_full      (q_full)
    );

    // queue keeps loads and reads in order so a read sees earlier loads
    hmu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (f_valid),
        .push_op (f_op),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .head    (q_head)
    );

    // back: real and imaginary planes read in parallel at the same slot,
    // sign of the imaginary word flipped for mirrored pairs
    hmu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .done      (done),
        .real_bits (real_bits),
        .imag_bits (imag_bits)
    );

endmodule
`default_nettype wire
